// File: design/lttc_pkg.sv
// ----------------------------------------------------------------------------
// lttc_pkg
// Types and constants shared by the lidar time-to-collision checker files.
// ----------------------------------------------------------------------------
package lttc_pkg;

	// Operation codes of an input item.
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_VEL  = 2'd1;
	localparam logic [1:0] OP_SCAN = 2'd2;

	// Shared multiplier geometry: a 16-bit magnitude times a 31-bit magnitude.
	localparam int MUL_A_W = 16;
	localparam int MUL_B_W = 31;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Milliseconds per second, and the Q1.14 scale of the cosine.
	localparam logic [MUL_B_W-1:0] MS_PER_S = MUL_B_W'(1000);
	localparam int                 COS_FRAC = 14;
	localparam int                 LHS_W    = 26;

	localparam logic [15:0] THR_RESET = 16'd500;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]         operation;
		logic [9:0]         beam_index;
		logic [15:0]        range_mm;
		logic signed [15:0] entry_cosine;
		logic [15:0]        entry_car_distance;
		logic signed [15:0] speed;
		logic               last_beam;
	} item_t;

	typedef struct packed {
		logic        scan_collided;
		logic [9:0]  hit_beam;
		logic        collision_flag;
		logic [15:0] collisions_total;
	} result_t;

	// Operands handed to the shared multiplier.
	typedef struct packed {
		logic               en;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL_N,
		ST_MUL_T,
		ST_CMP,
		ST_FIN
	} state_t;

endpackage

// File: design/lidar_ttc_collision_checker_top.sv
// ----------------------------------------------------------------------------
// lidar_ttc_collision_checker_top
// Per-beam time-to-collision check over lidar scans with one shared multiplier.
// ----------------------------------------------------------------------------
//
//  channel   signals                               direction
//  item      item_valid, item_stall, item          in  (item_t)
//  result    result_valid, result_stall, result    out (result_t)
//  cfg       cfg_valid, cfg_ready, cfg_data        in  (ttc_threshold_ms)
//
// Load, velocity and unused items are taken in the idle state. A scan beam that
// is checked runs through a table read, then three passes through the one multiplier
// (speed times cosine, range gap times 1000, threshold times |p|), a compare
// and a finish state; an unchecked beam goes straight to the finish state. The
// multiplier sets the pace. Reset clears all control state and sets the threshold
// to 500 ms; the tables hold garbage until loaded. A last beam waits in its finish
// state while an earlier result is still held by a stalled result channel.
module lidar_ttc_collision_checker_top #(
	parameter int MAX_BEAMS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lttc_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output lttc_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data
);

	localparam int AW = $clog2(MAX_BEAMS);

	lttc_pkg::state_t state_q, state_d;

	logic [15:0] thr_q;
	logic [15:0] vel_q;
	logic        in_coll_q;
	logic [15:0] count_q;
	logic        hit_scan_q;
	logic [9:0]  first_hit_q;

	logic [9:0]  beam_q;
	logic [15:0] range_q;
	logic        last_q;

	logic [15:0] an_q;
	logic        n_neg_q;
	logic        n_pos_q;
	logic        p_neg_q;
	logic        p_zero_q;
	logic [lttc_pkg::MUL_B_W-1:0] ap_q;
	logic [lttc_pkg::LHS_W-1:0]   lhs_q;

	logic                        accept;
	logic                        idx_ok;
	logic [31:0]                 idx_ext;
	logic [AW-1:0]               addr;
	logic                        check;
	logic                        ram_we;
	logic                        ram_re;
	logic [31:0]                 ram_rdata;
	logic [15:0]                 rd_cos;
	logic [15:0]                 rd_dist;
	logic [16:0]                 n_diff;
	logic [15:0]                 n_mag;
	logic [15:0]                 cos_mag;
	logic [15:0]                 vel_mag;
	lttc_pkg::mul_req_t          mul_req;
	logic [lttc_pkg::PROD_W-1:0] prod_q;
	logic [lttc_pkg::PROD_W-1:0] lhs_full;
	logic                        hit_now;
	logic                        out_free;
	logic                        out_load;

	assign accept    = item_valid && !item_stall;
	assign cfg_ready = 1'b1;
	assign idx_ext   = 32'(item.beam_index);
	assign addr      = idx_ext[AW-1:0];
	assign idx_ok    = idx_ext < 32'(MAX_BEAMS);
	assign check     = (vel_q != 16'd0) && !hit_scan_q && idx_ok;

	assign ram_we = accept && (item.operation == lttc_pkg::OP_LOAD) && idx_ok;
	assign ram_re = accept && (item.operation == lttc_pkg::OP_SCAN);

	lttc_ram #(
		.WIDTH(32),
		.DEPTH(MAX_BEAMS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr),
		.wdata({item.entry_cosine, item.entry_car_distance}),
		.re   (ram_re),
		.raddr(addr),
		.rdata(ram_rdata)
	);

	assign rd_cos  = ram_rdata[31:16];
	assign rd_dist = ram_rdata[15:0];

	// Range gap n is 17-bit signed; its magnitude always fits 16 bits.
	assign n_diff  = {1'b0, range_q} - {1'b0, rd_dist};
	assign n_mag   = n_diff[16] ? 16'(-n_diff) : n_diff[15:0];
	assign cos_mag = rd_cos[15] ? 16'(-rd_cos) : rd_cos;
	assign vel_mag = vel_q[15] ? 16'(-vel_q) : vel_q;

	lttc_mul u_mul (
		.clk   (clk),
		.req   (mul_req),
		.prod_q(prod_q)
	);

	assign lhs_full = {7'd0, lhs_q, {lttc_pkg::COS_FRAC{1'b0}}};
	assign hit_now  = !p_zero_q && !(n_neg_q && !p_neg_q) && !(n_pos_q && p_neg_q)
		&& (lhs_full < prod_q);

	assign out_free = !result_valid || !result_stall;

	always_comb begin
		state_d        = state_q;
		item_stall     = 1'b1;
		out_load       = 1'b0;
		mul_req.en     = 1'b0;
		mul_req.a      = '0;
		mul_req.b      = '0;
		unique case (state_q)
			lttc_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid && (item.operation == lttc_pkg::OP_SCAN)) begin
					state_d = check ? lttc_pkg::ST_READ : lttc_pkg::ST_FIN;
				end
			end
			lttc_pkg::ST_READ: begin
				mul_req.en = 1'b1;
				mul_req.a  = cos_mag;
				mul_req.b  = lttc_pkg::MUL_B_W'(vel_mag);
				state_d    = lttc_pkg::ST_MUL_N;
			end
			lttc_pkg::ST_MUL_N: begin
				mul_req.en = 1'b1;
				mul_req.a  = an_q;
				mul_req.b  = lttc_pkg::MS_PER_S;
				state_d    = lttc_pkg::ST_MUL_T;
			end
			lttc_pkg::ST_MUL_T: begin
				mul_req.en = 1'b1;
				mul_req.a  = thr_q;
				mul_req.b  = ap_q;
				state_d    = lttc_pkg::ST_CMP;
			end
			lttc_pkg::ST_CMP: begin
				state_d = lttc_pkg::ST_FIN;
			end
			lttc_pkg::ST_FIN: begin
				if (!last_q) begin
					state_d = lttc_pkg::ST_IDLE;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = lttc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lttc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lttc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Architectural state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= lttc_pkg::THR_RESET;
			vel_q        <= '0;
			in_coll_q    <= 1'b0;
			count_q      <= '0;
			hit_scan_q   <= 1'b0;
			first_hit_q  <= '0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (accept && (item.operation == lttc_pkg::OP_VEL)) begin
				vel_q <= item.speed;
			end
			if ((state_q == lttc_pkg::ST_CMP) && hit_now) begin
				hit_scan_q  <= 1'b1;
				first_hit_q <= beam_q;
				in_coll_q   <= 1'b1;
				if (count_q != lttc_pkg::COUNT_MAX) begin
					count_q <= count_q + 16'd1;
				end
			end
			if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
			if (out_load) begin
				result_valid <= 1'b1;
				hit_scan_q   <= 1'b0;
				first_hit_q  <= '0;
				if (!hit_scan_q && (vel_q != 16'd0)) begin
					in_coll_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result.scan_collided    <= hit_scan_q;
			result.hit_beam         <= hit_scan_q ? first_hit_q : 10'd0;
			result.collision_flag   <= hit_scan_q || (in_coll_q && (vel_q == 16'd0));
			result.collisions_total <= count_q;
		end
	end

	// Operands and partial results of the beam under check.
	always_ff @(posedge clk) begin
		if (accept) begin
			beam_q  <= item.beam_index;
			range_q <= item.range_mm;
			last_q  <= item.last_beam;
		end
		if (state_q == lttc_pkg::ST_READ) begin
			an_q     <= n_mag;
			n_neg_q  <= n_diff[16];
			n_pos_q  <= !n_diff[16] && (n_diff != 17'd0);
			p_neg_q  <= vel_q[15] ^ rd_cos[15];
			p_zero_q <= rd_cos == 16'd0;
		end
		if (state_q == lttc_pkg::ST_MUL_N) begin
			ap_q <= prod_q[lttc_pkg::MUL_B_W-1:0];
		end
		if (state_q == lttc_pkg::ST_MUL_T) begin
			lhs_q <= prod_q[lttc_pkg::LHS_W-1:0];
		end
	end

	a_no_beam_without_hit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.scan_collided |-> result.hit_beam == 10'd0)
		else $error("hit_beam nonzero on a scan without a collision");

	a_hit_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.scan_collided |-> result.collision_flag)
		else $error("collision reported without collision flag");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		##1 count_q >= $past(count_q))
		else $error("collision count decreased");

	a_hit_implies_coll: assert property (@(posedge clk) disable iff (!arst_n)
		hit_scan_q |-> in_coll_q)
		else $error("scan hit recorded while not in collision");

endmodule

// File: design/lttc_ram.sv
// ----------------------------------------------------------------------------
// lttc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lttc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/lttc_mul.sv
// ----------------------------------------------------------------------------
// lttc_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module lttc_mul (
	input  logic                       clk,
	input  lttc_pkg::mul_req_t         req,
	output logic [lttc_pkg::PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= lttc_pkg::PROD_W'(req.a) * lttc_pkg::PROD_W'(req.b);
		end
	end

endmodule

// File: dv/tb_lidar_ttc_collision_checker_top.sv
// ----------------------------------------------------------------------------
// tb_lidar_ttc_collision_checker_top
// Self-checking bench for the lidar time-to-collision checker. A queue-fed
// driver sends table loads, speed updates and scan beams in random bursts. A
// monitor keeps a cycle-free model of the tables, speed and collision state,
// predicts one report per scan and compares it with the block's output.
// Threshold settings are swept between phases, including both extremes and a
// long result hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_lidar_ttc_collision_checker_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED      = 2'd3;
	localparam int         NUM_BEAMS      = 1024;
	localparam int         SETTLE_CYCLES  = 12;
	localparam int         WATCHDOG_LIMIT = 4000;
	localparam int         REPORT_LIMIT   = 10;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	lttc_pkg::item_t   item_bus     = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	lttc_pkg::result_t result_bus;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic [15:0]       cfg_data     = '0;

	lidar_ttc_collision_checker_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item_bus),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result_bus),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Collision state as the block should hold it.
	logic signed [15:0] beam_cos [NUM_BEAMS];
	logic        [15:0] beam_edge [NUM_BEAMS];
	logic signed [15:0] cur_speed       = '0;
	logic        [15:0] threshold_ms    = lttc_pkg::THR_RESET;
	logic        [15:0] collision_tally = '0;
	logic        [9:0]  scan_hit_beam   = '0;
	bit                 colliding       = 1'b0;
	bit                 scan_has_hit    = 1'b0;
	lttc_pkg::result_t  scan_reports_due [$];

	// Stimulus side: pending items and what the generator knows of the tables.
	lttc_pkg::item_t items_to_send [$];
	logic [15:0]     gen_edge [NUM_BEAMS];
	bit              gen_loaded [NUM_BEAMS];
	logic [9:0]      loaded_beams [$];

	int items_queued     = 0;
	int useful_queued    = 0;
	int items_accepted   = 0;
	int reports_seen     = 0;
	int reports_hit      = 0;
	int threshold_writes = 0;
	int mismatches       = 0;
	int idle_cycles      = 0;

	// Handshake knobs, changed by the sequencer between phases.
	int          send_max_gap   = 4;
	int          send_max_burst = 8;
	int          gap_left       = 0;
	int          burst_left     = 0;
	stall_mode_t stall_mode     = STALL_RANDOM;
	int          stall_pct      = 25;
	int          stall_period   = 5;
	int          stall_duty     = 2;
	int          stall_phase    = 0;
	int          holdoff_cycles = 0;
	bit          item_taken     = 1'b0;

	function automatic bit beam_closing(input logic [9:0] idx, input logic [15:0] rng);
		longint p, n, an, ap;
		p = longint'(cur_speed) * longint'(beam_cos[idx]);
		n = longint'(rng) - longint'(beam_edge[idx]);
		if (p == 0)
			return 1'b0;
		if ((n < 0 && p > 0) || (n > 0 && p < 0))
			return 1'b0;
		an = (n < 0) ? -n : n;
		ap = (p < 0) ? -p : p;
		return an * 1000 * 16384 < longint'(threshold_ms) * ap;
	endfunction

	function automatic void advance_collision_state(input lttc_pkg::item_t it);
		lttc_pkg::result_t rpt;
		case (it.operation)
			lttc_pkg::OP_LOAD: begin
				beam_cos[it.beam_index]  = it.entry_cosine;
				beam_edge[it.beam_index] = it.entry_car_distance;
			end
			lttc_pkg::OP_VEL: cur_speed = it.speed;
			lttc_pkg::OP_SCAN: begin
				if (cur_speed != 0 && !scan_has_hit &&
					beam_closing(it.beam_index, it.range_mm)) begin
					scan_has_hit  = 1'b1;
					scan_hit_beam = it.beam_index;
					colliding     = 1'b1;
					if (collision_tally != lttc_pkg::COUNT_MAX)
						collision_tally++;
				end
				if (it.last_beam) begin
					// With the car standing still a clean scan says nothing new.
					if (!scan_has_hit && cur_speed != 0)
						colliding = 1'b0;
					rpt.scan_collided    = scan_has_hit;
					rpt.hit_beam         = scan_has_hit ? scan_hit_beam : '0;
					rpt.collision_flag   = colliding;
					rpt.collisions_total = collision_tally;
					scan_reports_due     = {scan_reports_due, rpt};
					scan_has_hit  = 1'b0;
					scan_hit_beam = '0;
				end
			end
			default: ;
		endcase
	endfunction

	// Driver: a new item is offered only once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_taken)) begin
			if (gap_left > 0 || items_to_send.size() == 0) begin
				item_valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				item_bus   <= items_to_send.pop_front();
				item_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, send_max_burst);
					gap_left   = (send_max_gap == 0) ? 0 : $urandom_range(0, send_max_gap);
				end
			end
		end
	end

	// Result receiver.
	always @(negedge clk) begin
		if (holdoff_cycles > 0) begin
			result_stall <= 1'b1;
			holdoff_cycles--;
		end else begin
			case (stall_mode)
				STALL_NONE:   result_stall <= 1'b0;
				STALL_RANDOM: result_stall <= ($urandom_range(0, 99) < stall_pct);
				default:      result_stall <= (stall_phase % stall_period) < stall_duty;
			endcase
			stall_phase++;
		end
	end

	always @(posedge clk) begin : monitor
		lttc_pkg::result_t want;
		if (arst_n) begin
			item_taken <= item_valid && !item_stall;
			if (result_valid && !result_stall) begin
				if (scan_reports_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected scan report: collided=%0b beam=%0d flag=%0b total=%0d",
							result_bus.scan_collided, result_bus.hit_beam,
							result_bus.collision_flag, result_bus.collisions_total);
				end else begin
					want = scan_reports_due.pop_front();
					reports_seen++;
					if (want.scan_collided)
						reports_hit++;
					if (want.scan_collided !== result_bus.scan_collided ||
						want.hit_beam !== result_bus.hit_beam ||
						want.collision_flag !== result_bus.collision_flag ||
						want.collisions_total !== result_bus.collisions_total) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("scan report %0d mismatch: expected collided=%0b beam=%0d flag=%0b total=%0d",
								reports_seen, want.scan_collided, want.hit_beam,
								want.collision_flag, want.collisions_total);
							$display("    got collided=%0b beam=%0d flag=%0b total=%0d",
								result_bus.scan_collided, result_bus.hit_beam,
								result_bus.collision_flag, result_bus.collisions_total);
						end
					end
				end
			end
			if (item_valid && !item_stall) begin
				advance_collision_state(item_bus);
				items_accepted++;
			end
			if (cfg_valid && cfg_ready) begin
				threshold_ms = cfg_data;
				threshold_writes++;
			end
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else if (items_accepted != items_queued || scan_reports_due.size() != 0 || cfg_valid)
				idle_cycles++;
			else
				idle_cycles = 0;
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	function automatic lttc_pkg::item_t random_item();
		lttc_pkg::item_t it;
		it.operation          = 2'($urandom_range(0, 3));
		it.beam_index         = 10'($urandom);
		it.range_mm           = 16'($urandom);
		it.entry_cosine       = 16'($urandom);
		it.entry_car_distance = 16'($urandom);
		it.speed              = 16'($urandom);
		it.last_beam          = 1'($urandom);
		return it;
	endfunction

	function automatic lttc_pkg::item_t unused_item();
		lttc_pkg::item_t it;
		it           = random_item();
		it.operation = OP_UNUSED;
		return it;
	endfunction

	function automatic lttc_pkg::item_t load_item(input logic [9:0] idx,
		input logic [15:0] cos_v, input logic [15:0] edge_mm);
		lttc_pkg::item_t it;
		it                    = random_item();
		it.operation          = lttc_pkg::OP_LOAD;
		it.beam_index         = idx;
		it.entry_cosine       = cos_v;
		it.entry_car_distance = edge_mm;
		return it;
	endfunction

	function automatic lttc_pkg::item_t speed_item(input logic [15:0] spd);
		lttc_pkg::item_t it;
		it           = random_item();
		it.operation = lttc_pkg::OP_VEL;
		it.speed     = spd;
		return it;
	endfunction

	function automatic lttc_pkg::item_t scan_item(input logic [9:0] idx,
		input logic [15:0] rng, input bit last);
		lttc_pkg::item_t it;
		it            = random_item();
		it.operation  = lttc_pkg::OP_SCAN;
		it.beam_index = idx;
		it.range_mm   = rng;
		it.last_beam  = last;
		return it;
	endfunction

	function automatic void queue_item(input lttc_pkg::item_t it);
		if (it.operation == lttc_pkg::OP_LOAD) begin
			if (!gen_loaded[it.beam_index])
				loaded_beams = {loaded_beams, it.beam_index};
			gen_loaded[it.beam_index] = 1'b1;
			gen_edge[it.beam_index]   = it.entry_car_distance;
		end
		if (it.operation != OP_UNUSED)
			useful_queued++;
		items_queued++;
		items_to_send = {items_to_send, it};
	endfunction

	function automatic logic [15:0] pick_cosine();
		case ($urandom_range(0, 9))
			0:       return 16'sd16384;
			1:       return -16'sd16384;
			2:       return '0;
			default: return 16'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic logic [15:0] pick_speed();
		int k, mag;
		k   = $urandom_range(0, 9);
		mag = $urandom_range(300, 12000);
		if (k == 0)
			return '0;
		if (k < 5)
			return 16'($urandom_range(0, 1) ? mag : -mag);
		return 16'($urandom);
	endfunction

	// Scans only touch beams already loaded; ranges cluster around the car
	// edge so that closing gaps within the threshold actually occur.
	function automatic logic [15:0] pick_range(input logic [9:0] idx);
		int k, r;
		k = $urandom_range(0, 9);
		if (k < 2)
			return gen_edge[idx];
		if (k < 6) begin
			r = int'(gen_edge[idx]) + int'($urandom_range(0, 3000)) - 1500;
			if (r < 0)
				r = 0;
			if (r > 65535)
				r = 65535;
			return 16'(r);
		end
		if (k == 6)
			return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		return 16'($urandom);
	endfunction

	function automatic void queue_scan(input int beams, input bit ends);
		logic [9:0] bm;
		for (int b = 0; b < beams; b++) begin
			bm = loaded_beams[$urandom_range(0, loaded_beams.size() - 1)];
			queue_item(scan_item(bm, pick_range(bm), ends && b == beams - 1));
		end
	endfunction

	task automatic queue_random_traffic(input int budget);
		int start, kind, nloads;
		start = useful_queued;
		while (useful_queued - start < budget) begin
			kind = $urandom_range(0, 19);
			if (kind < 15) begin
				nloads = $urandom_range(0, 2);
				for (int k = 0; k < nloads; k++)
					queue_item(load_item(10'($urandom_range(0, NUM_BEAMS - 1)), pick_cosine(),
						$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 5000))));
				if ($urandom_range(0, 1))
					queue_item(speed_item(pick_speed()));
				queue_scan($urandom_range(1, 6), 1'b1);
			end else if (kind == 15) begin
				queue_item(unused_item());
			end else if (kind < 18) begin
				// A scan cut short runs on into whatever scan follows it.
				queue_scan($urandom_range(1, 3), 1'b0);
			end else begin
				queue_item(speed_item('0));
				queue_scan($urandom_range(1, 3), 1'b1);
			end
		end
	endtask

	task automatic wait_for_drain();
		do @(negedge clk);
		while (items_accepted != items_queued || scan_reports_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] thr_value);
		int target;
		target = threshold_writes + 1;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= thr_value;
		do @(negedge clk);
		while (threshold_writes < target);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [15:0] thr_next;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at the reset threshold of 500 ms.
		queue_item(load_item(10'd0, 16'sd16384, 16'd0));
		queue_item(load_item(10'd1023, -16'sd16384, 16'hFFFF));
		queue_item(load_item(10'd512, 16'sd0, 16'd1000));
		queue_item(load_item(10'd341, 16'sd11585, 16'd300));
		queue_item(load_item(10'd682, -16'sd8000, 16'd40000));
		queue_item(unused_item());
		// Standing still: the scan is reported but nothing is checked.
		queue_item(scan_item(10'd0, 16'd100, 1'b1));
		queue_item(speed_item(16'sd32767));
		// Zero cosine cannot hit; a zero gap on a receding beam does.
		queue_item(scan_item(10'd512, 16'd1000, 1'b0));
		queue_item(scan_item(10'd1023, 16'hFFFF, 1'b0));
		queue_item(scan_item(10'd0, 16'd0, 1'b1));
		queue_item(scan_item(10'd0, 16'hFFFF, 1'b1));
		queue_item(speed_item(-16'sd32768));
		// Gap and closing speed of opposite sign, then a true reverse hit.
		queue_item(scan_item(10'd682, 16'd39990, 1'b0));
		queue_item(scan_item(10'd341, 16'd0, 1'b1));
		queue_item(speed_item(16'sd0));
		queue_item(scan_item(10'd0, 16'd5, 1'b1));

		for (int ph = 0; ph < 8; ph++) begin
			wait_for_drain();
			case (ph)
				0:       thr_next = 16'hFFFF;
				1:       thr_next = 16'd0;
				2:       thr_next = 16'd1;
				5:       thr_next = lttc_pkg::THR_RESET;
				7:       thr_next = 16'd2000;
				default: thr_next = 16'($urandom);
			endcase
			write_threshold(thr_next);
			@(posedge clk);
			if (ph == 1) begin
				send_max_gap = 0;
				stall_mode   = STALL_NONE;
			end else begin
				send_max_gap   = $urandom_range(1, 10);
				send_max_burst = $urandom_range(0, 15);
				stall_mode     = (ph % 2 == 0) ? STALL_RANDOM : STALL_PERIODIC;
				stall_pct      = $urandom_range(20, 60);
				stall_period   = $urandom_range(2, 9);
				stall_duty     = $urandom_range(1, stall_period - 1);
			end
			// Hold results back long enough for the block to back up its input.
			if (ph == 3)
				holdoff_cycles = 400;
			queue_random_traffic(95);
			wait_for_drain();
			queue_random_traffic(95);
		end

		wait_for_drain();
		repeat (20) @(posedge clk);

		$display("checked %0d scan reports (%0d with a hit) from %0d input transactions",
			reports_seen, reports_hit, items_accepted);
		$display("covered %0d threshold settings and a long result hold-off",
			threshold_writes);
		if (mismatches == 0 && scan_reports_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
